### rtl/fbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box culling unit
// Request codes, field widths and the queue entry type.
// ----------------------------------------------------------------------------
package fbc_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_TEST    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  localparam int unsigned ValW   = 32;
  localparam int unsigned CoefW  = 33;
  localparam int unsigned NumPl  = 6;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    req_e                   req;
    logic [3:0]             idx;
    logic signed [ValW-1:0] val;
    logic signed [ValW-1:0] mnx, mny, mnz, mxx, mxy, mxz;
  } cmd_t;

endpackage

### rtl/fbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_front: command intake and queue
// Accept commands, drop unused codes, and queue them for the back end.
// ----------------------------------------------------------------------------
module fbc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  fbc_pkg::cmd_t   cmd_i,
  output logic            full_o,
  output logic            q_valid_o,
  output fbc_pkg::cmd_t   q_cmd_o,
  input  logic            q_pop_i
);
  localparam int unsigned Aw = $clog2(fbc_pkg::QDepth);

  fbc_pkg::cmd_t          mem_q [fbc_pkg::QDepth];
  logic [Aw-1:0]          wp_q, rp_q;
  logic [Aw:0]            cnt_q, cnt_d;
  logic                   push;

  assign full_o    = (cnt_q == (Aw+1)'(fbc_pkg::QDepth));
  assign push      = start_i && !full_o && (cmd_i.req != fbc_pkg::REQ_NONE);
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) cnt_d = cnt_q + 1'b1;
    else if (!push && q_pop_i && q_valid_o) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= wp_q + 1'b1;
      if (q_pop_i && q_valid_o) rp_q <= rp_q + 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(fbc_pkg::QDepth)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push) else $error("push while full");
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wp_q == rp_q)) else $error("pointer mismatch");
endmodule

### rtl/fbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_back: matrix/plane stores and sequential plane evaluator
// Execute loads and extracts; test a box one plane per cycle.
// ----------------------------------------------------------------------------
module fbc_back #(
  parameter int unsigned FracBits = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  fbc_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          busy_o,
  output logic          done_o,
  output logic          box_visible_o
);
  localparam int unsigned PW = 2*fbc_pkg::ValW + 2;   // product width
  localparam int unsigned AW = PW + 3;                 // accumulator width
  localparam int unsigned CoefW = fbc_pkg::CoefW;

  logic signed [fbc_pkg::ValW-1:0]  mat_q [16];
  logic signed [fbc_pkg::CoefW-1:0] pl_q  [24];
  fbc_pkg::cmd_t                    cur_q;
  logic                             act_q, vis_q, done_q;
  logic [2:0]                       pi_q;
  logic signed [fbc_pkg::CoefW-1:0] a, b, c, d;
  logic signed [fbc_pkg::ValW-1:0]  px, py, pz;
  logic signed [PW-1:0]             prx, pry, prz;
  logic signed [AW-1:0]             sum;
  logic [4:0]                       base;

  assign busy_o  = act_q;
  assign q_pop_o = q_valid_i && !act_q;
  assign done_o  = done_q;
  assign box_visible_o = vis_q;

  always_comb begin
    base = {pi_q[2:0], 2'b00};
    a = pl_q[base];
    b = pl_q[base + 5'd1];
    c = pl_q[base + 5'd2];
    d = pl_q[base + 5'd3];
    px = (a > 0) ? cur_q.mxx : cur_q.mnx;
    py = (b > 0) ? cur_q.mxy : cur_q.mny;
    pz = (c > 0) ? cur_q.mxz : cur_q.mnz;
    prx = PW'(a) * PW'(px);
    pry = PW'(b) * PW'(py);
    prz = PW'(c) * PW'(pz);
    sum = AW'(prx) + AW'(pry) + AW'(prz) + (AW'(d) <<< FracBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
      for (int i = 0; i < 24; i++) pl_q[i] <= '0;
      act_q <= 1'b0;
      done_q <= 1'b0;
      vis_q <= 1'b0;
      pi_q <= '0;
      cur_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (q_pop_o) begin
        unique case (q_cmd_i.req)
          fbc_pkg::REQ_LOAD: mat_q[q_cmd_i.idx] <= q_cmd_i.val;
          fbc_pkg::REQ_EXTRACT: begin
            for (int r = 0; r < 4; r++) begin
              pl_q[r]      <= CoefW'(mat_q[r*4+3]) + CoefW'(mat_q[r*4]);
              pl_q[4+r]    <= CoefW'(mat_q[r*4+3]) - CoefW'(mat_q[r*4]);
              pl_q[8+r]    <= CoefW'(mat_q[r*4+3]) + CoefW'(mat_q[r*4+1]);
              pl_q[12+r]   <= CoefW'(mat_q[r*4+3]) - CoefW'(mat_q[r*4+1]);
              pl_q[16+r]   <= CoefW'(mat_q[r*4+2]);
              pl_q[20+r]   <= CoefW'(mat_q[r*4+3]) - CoefW'(mat_q[r*4+2]);
            end
          end
          fbc_pkg::REQ_TEST: begin
            cur_q <= q_cmd_i;
            act_q <= 1'b1;
            pi_q  <= '0;
            vis_q <= 1'b1;
          end
          default: ;
        endcase
      end else if (act_q) begin
        if (sum < 0) vis_q <= 1'b0;
        if (pi_q == 3'(fbc_pkg::NumPl - 1)) begin
          act_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          pi_q <= pi_q + 3'd1;
        end
      end
    end
  end

  a_pi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (pi_q < 3'(fbc_pkg::NumPl))) else $error("plane index out of range");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !act_q) else $error("done while active");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> !q_pop_o) else $error("pop while testing");
endmodule

### rtl/frustum_box_culling_unit.sv
`timescale 1ns / 1ps
// A box test passes through the queue, then is evaluated one plane per cycle
// on the shared evaluator for 6 planes before its result is strobed.
// The back end takes a new box test only after the current one is done; loads and extracts complete when popped.
// Reset: asynchronous active low, clears matrix, planes, queue and control.
// The result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// frustum_box_culling_unit: frustum plane extraction and AABB culling
// Front queues commands; back holds stores and runs the plane evaluator.
// ----------------------------------------------------------------------------
module frustum_box_culling_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic [3:0]          elem_index_i,
  input  logic signed [31:0]  elem_value_i,
  input  logic signed [31:0]  box_min_x_i,
  input  logic signed [31:0]  box_min_y_i,
  input  logic signed [31:0]  box_min_z_i,
  input  logic signed [31:0]  box_max_x_i,
  input  logic signed [31:0]  box_max_y_i,
  input  logic signed [31:0]  box_max_z_i,
  output logic                done_o,
  output logic                box_visible_o
);
  fbc_pkg::cmd_t cmd, q_cmd;
  logic          q_valid, q_pop, back_busy;

  // Pack the transaction into one queue entry.
  always_comb begin
    cmd.req = fbc_pkg::req_e'(req_type_i);
    cmd.idx = elem_index_i;
    cmd.val = elem_value_i;
    cmd.mnx = box_min_x_i;
    cmd.mny = box_min_y_i;
    cmd.mnz = box_min_z_i;
    cmd.mxx = box_max_x_i;
    cmd.mxy = box_max_y_i;
    cmd.mxz = box_max_z_i;
  end

  fbc_front u_front (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(cmd), .full_o(busy),
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  fbc_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .busy_o(back_busy), .done_o, .box_visible_o
  );

  a_done_not_busy_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !back_busy) else $error("strobe during test");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("strobe longer than one cycle");
  a_pop_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
endmodule

### tb/fbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_checker: visibility predictor and result checker
// Mirrors matrix and plane state from accepted commands, predicts each box
// test verdict and compares it against the done-strobed result.
// ----------------------------------------------------------------------------
module fbc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  input  logic               done_o,
  input  logic               box_visible_o,
  output int unsigned        fail_count,
  output int unsigned        pending_count,
  output logic               accepted_any
);

  localparam int FracBits = 16;
  localparam int unsigned CoefW = fbc_pkg::CoefW;

  logic signed [31:0]      mat_q [16];
  logic signed [CoefW-1:0] plane_q [24];
  bit                      visible_q [$];

  function automatic bit box_visible(input logic signed [31:0] lo [3],
                                     input logic signed [31:0] hi [3]);
    logic signed [127:0] acc;
    logic signed [CoefW-1:0] a;
    logic signed [31:0] v;
    for (int p = 0; p < fbc_pkg::NumPl; p++) begin
      acc = 128'(plane_q[p*4+3]) <<< FracBits;
      for (int k = 0; k < 3; k++) begin
        a = plane_q[p*4+k];
        v = (a > 0) ? hi[k] : lo[k];
        acc = acc + 128'(a) * 128'(v);
      end
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  assign accepted_any  = (start && !busy) || done_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [CoefW-1:0] c3;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
      for (int i = 0; i < 24; i++) plane_q[i] = '0;
      visible_q.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      // Check the strobed result before queuing this edge's prediction
      if (done_o) begin
        if (visible_q.size() == 0) begin
          $error("box_visible: unexpected result %0d", box_visible_o);
          fail_count <= fail_count + 1;
        end else begin
          if (visible_q[0] !== box_visible_o) begin
            $error("box_visible: expected %0d actual %0d", visible_q[0], box_visible_o);
            fail_count <= fail_count + 1;
          end
          void'(visible_q.pop_front());
        end
      end
      if (start && !busy) begin
        case (fbc_pkg::req_e'(req_type_i))
          fbc_pkg::REQ_LOAD: mat_q[elem_index_i] <= elem_value_i;
          fbc_pkg::REQ_EXTRACT: begin
            for (int r = 0; r < 4; r++) begin
              c3 = CoefW'(mat_q[r*4+3]);
              plane_q[0*4+r] = c3 + CoefW'(mat_q[r*4+0]);
              plane_q[1*4+r] = c3 - CoefW'(mat_q[r*4+0]);
              plane_q[2*4+r] = c3 + CoefW'(mat_q[r*4+1]);
              plane_q[3*4+r] = c3 - CoefW'(mat_q[r*4+1]);
              plane_q[4*4+r] = CoefW'(mat_q[r*4+2]);
              plane_q[5*4+r] = c3 - CoefW'(mat_q[r*4+2]);
            end
          end
          fbc_pkg::REQ_TEST: begin
            lo = '{box_min_x_i, box_min_y_i, box_min_z_i};
            hi = '{box_max_x_i, box_max_y_i, box_max_z_i};
            visible_q.push_back(box_visible(lo, hi));
          end
          default: ;
        endcase
      end
      pending_count <= visible_q.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: frustum box culling unit testbench
// Loads matrices, extracts planes and fires box tests, directed then random;
// a checker beside the block predicts and compares every visibility result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomTxns    = 1350;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type_i = fbc_pkg::REQ_NONE;
  logic [3:0]         elem_index_i = '0;
  logic signed [31:0] elem_value_i = '0;
  logic signed [31:0] box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  logic signed [31:0] box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic               done_o;
  logic               box_visible_o;
  int unsigned        fail_count, pending_count;
  logic               accepted_any;
  int unsigned        idle_cycles = 0;
  bit                 no_gaps = 1'b0;

  always #10 clk_i = ~clk_i;

  frustum_box_culling_unit dut (.*);
  fbc_checker u_checker (.*);

  // Watchdog: count cycles without any accepted transaction or result strobe
  always @(posedge clk_i) begin
    idle_cycles <= accepted_any ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("frustum_box_culling_unit verification failed");
      $finish;
    end
  end

  // Pick a value from the edges of the signed range, zero, a full random word or a moderate random one
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  // Drive one transaction; hold start until it is accepted
  task automatic issue(input fbc_pkg::req_e req, input logic [3:0] idx,
                       input logic signed [31:0] val,
                       input logic signed [31:0] b [6]);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 30) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start        <= 1'b1;
    req_type_i   <= req;
    elem_index_i <= idx;
    elem_value_i <= val;
    box_min_x_i  <= b[0]; box_min_y_i <= b[1]; box_min_z_i <= b[2];
    box_max_x_i  <= b[3]; box_max_y_i <= b[4]; box_max_z_i <= b[5];
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic random_box(output logic signed [31:0] b [6]);
    for (int i = 0; i < 6; i++) b[i] = pick_value();
    // Mostly well-ordered boxes; leave some inverted as given
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 3; i++)
        if (b[i] > b[i+3]) begin
          b[i] = b[i] ^ b[i+3]; b[i+3] = b[i] ^ b[i+3]; b[i] = b[i] ^ b[i+3];
        end
    end
  endtask

  task automatic load_matrix(input bit extremes);
    logic signed [31:0] z [6];
    z = '{default: '0};
    for (int i = 0; i < 16; i++)
      issue(fbc_pkg::REQ_LOAD, 4'(i),
            extremes ? (i[0] ? 32'sh7fffffff : 32'sh80000000) : pick_value(), z);
  endtask

  initial begin
    logic signed [31:0] b [6];
    logic signed [31:0] z [6];
    z = '{default: '0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Planes never extracted: every box is visible
    b = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    issue(fbc_pkg::REQ_TEST, '0, '0, b);
    issue(fbc_pkg::REQ_NONE, 4'hf, 32'sh7fffffff, b);
    // Extreme matrix, then extreme and inverted boxes
    load_matrix(1'b1);
    issue(fbc_pkg::REQ_EXTRACT, '0, '0, z);
    issue(fbc_pkg::REQ_TEST, '0, '0, b);
    b = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh80000000, 32'sh80000000, 32'sh80000000};
    issue(fbc_pkg::REQ_TEST, '0, '0, b);
    issue(fbc_pkg::REQ_TEST, '0, '0, z);

    // Hold off until the block has drained every expected result
    drain();

    for (int n = 0; n < RandomTxns; ) begin
      no_gaps = (n >= 400 && n < 600);
      case ($urandom_range(0, 19))
        0: begin
          load_matrix(1'b0); issue(fbc_pkg::REQ_EXTRACT, '0, '0, z); n += 17;
        end
        1, 2: begin
          issue(fbc_pkg::REQ_LOAD, 4'($urandom()), pick_value(), z); n++;
        end
        3: begin issue(fbc_pkg::REQ_EXTRACT, '0, '0, z); n++; end
        4: begin
          random_box(b); issue(fbc_pkg::REQ_NONE, 4'($urandom()), $urandom(), b);
        end
        default: begin random_box(b); issue(fbc_pkg::REQ_TEST, '0, '0, b); n++; end
      endcase
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("frustum_box_culling_unit verification clean");
    end else begin
      $display("frustum_box_culling_unit verification failed");
    end
    $finish;
  end

endmodule
